### rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [1:0] ST_ENQ   = 2'd0;
  localparam logic [1:0] ST_DEQ   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] item_data;
    logic signed [31:0] item_priority;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_data;
    logic signed [31:0] out_priority;
  } out_t;

  // one stored queue entry
  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

endpackage

### rtl/core/spq_store.sv
module spq_store #(
  parameter int DEPTH = spq_pkg::CAPACITY_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  spq_pkg::entry_t       wr_entry,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output spq_pkg::entry_t       rd_entry
);

  spq_pkg::entry_t mem_r [DEPTH];
  spq_pkg::entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

### rtl/core/sorted_priority_queue.sv
// Results (acceptance to out_valid strobe): enqueue into a full store, dequeue on
//   an empty store and enqueue into an empty store are registered straight from idle;
//   dequeue uses S_DEQ_OUT; other enqueues walk S_ENQ_CMP past lower-priority entries.
// Throughput: one transaction at a time, bound by the single read and write port
//   of the entry store; busy drops in the strobe cycle, so the next one may start then.
// Reset (rst_n low, synchronous) empties the queue; the receiver cannot stall results.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::in_t  in_item,
  output logic          out_valid,
  output spq_pkg::out_t out_result
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W:0] CAP_L = (IDX_W + 1)'(CAPACITY);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_ENQ_CMP = 2'd1;
  localparam logic [1:0] S_ENQ_PUT = 2'd2;
  localparam logic [1:0] S_DEQ_OUT = 2'd3;

  // sequencer state
  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;    // physical slot of the queue head
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;      // logical slot being filled on enqueue
  spq_pkg::in_t     item_r, item_nxt;
  logic             out_valid_r, out_valid_nxt;
  spq_pkg::out_t    out_result_r, out_result_nxt;

  // store port
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_log, rd_log;
  spq_pkg::entry_t  wr_entry, rd_entry, new_entry;

  logic accept, is_full, is_empty, moves;

  // map a logical position (0 = head) to its physical slot in the ring
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] lpos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, lpos};
    if (sum >= CAP_L) begin
      sum = sum - CAP_L;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  // compare: the stored entry yields its slot when strictly lower in priority
  assign moves    = (rd_entry.prio < item_r.item_priority);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    item_nxt       = item_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = '0;
    wr_en          = 1'b0;
    wr_log         = '0;
    wr_entry       = '0;
    rd_en          = 1'b0;
    rd_log         = '0;
    new_entry.data = item_r.item_data;
    new_entry.prio = item_r.item_priority;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_item;
          if (in_item.kind == spq_pkg::KIND_ENQ) begin
            if (is_full) begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = spq_pkg::ST_FULL;
            end else if (is_empty) begin
              // nothing to walk past: drop the entry straight into the head slot
              wr_en                 = 1'b1;
              wr_log                = '0;
              wr_entry.data         = in_item.item_data;
              wr_entry.prio         = in_item.item_priority;
              count_nxt             = count_r + CNT_W'(1);
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = spq_pkg::ST_ENQ;
            end else begin
              // start the walk from the tail toward the head
              rd_en     = 1'b1;
              rd_log    = IDX_W'(count_r - CNT_W'(1));
              pos_nxt   = IDX_W'(count_r);
              state_nxt = S_ENQ_CMP;
            end
          end else begin
            if (is_empty) begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = spq_pkg::ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              rd_log    = '0;
              state_nxt = S_DEQ_OUT;
            end
          end
        end
      end

      S_ENQ_CMP: begin
        if (moves) begin
          // shift the lower-priority entry back one slot, fetch the next one unless at the head
          wr_en    = 1'b1;
          wr_log   = pos_r;
          wr_entry = rd_entry;
          if (pos_r == IDX_W'(1)) begin
            pos_nxt   = '0;
            state_nxt = S_ENQ_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_log  = pos_r - IDX_W'(2);
            pos_nxt = pos_r - IDX_W'(1);
          end
        end else begin
          // equal or higher priority ahead: the new entry lands right behind it
          wr_en                 = 1'b1;
          wr_log                = pos_r;
          wr_entry              = new_entry;
          count_nxt             = count_r + CNT_W'(1);
          out_valid_nxt         = 1'b1;
          out_result_nxt.status = spq_pkg::ST_ENQ;
          state_nxt             = S_IDLE;
        end
      end

      S_ENQ_PUT: begin
        wr_en                 = 1'b1;
        wr_log                = pos_r;
        wr_entry              = new_entry;
        count_nxt             = count_r + CNT_W'(1);
        out_valid_nxt         = 1'b1;
        out_result_nxt.status = spq_pkg::ST_ENQ;
        state_nxt             = S_IDLE;
      end

      S_DEQ_OUT: begin
        // head data is back from the store: hand it out and advance the ring
        out_valid_nxt               = 1'b1;
        out_result_nxt.status       = spq_pkg::ST_DEQ;
        out_result_nxt.out_data     = rd_entry.data;
        out_result_nxt.out_priority = rd_entry.prio;
        head_nxt                    = phys(head_r, IDX_W'(1));
        count_nxt                   = count_r - CNT_W'(1);
        state_nxt                   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: hold without reset
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    item_r       <= item_nxt;
    out_result_r <= out_result_nxt;
  end

  spq_store #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (phys(head_r, wr_log)),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (phys(head_r, rd_log)),
    .rd_entry (rd_entry)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // fill level never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // every result traces back to an accepted or running transaction
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a transaction");

  // a served dequeue removes exactly one entry
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_result_r.status == spq_pkg::ST_DEQ)
      |-> ((count_r + CNT_W'(1)) == $past(count_r)))
    else $error("dequeue did not drop one entry");

  // a stored enqueue adds exactly one entry
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_result_r.status == spq_pkg::ST_ENQ)
      |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("enqueue did not add one entry");

  // the insertion walk never runs while the store is full
  a_walk_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENQ_CMP || state_r == S_ENQ_PUT) |-> !is_full)
    else $error("insertion walk on a full store");

endmodule
